>>> hw/rtl/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent check forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SPQ_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define SPQ_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Field widths, default sizes, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int SPQ_QUEUE_DEPTH = 16;
  localparam int SPQ_TOKEN_BITS  = 16;

  localparam int FIELD_W  = 16;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RM_READ,
    ST_INS_SCAN,
    ST_INS_LAST
  } state_t;

endpackage

>>> hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue held in ascending token order in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start with in_req_type, in_token_in and in_cust_id_in; the request
//   transfers at a clock edge where start is high and busy is low. Insert
//   places the entry ahead of every held entry with an equal or larger token;
//   remove returns the head (smallest token). Every request gives exactly one
//   result, shown for one cycle with out_valid high; the receiver cannot
//   stall, so the result must be taken in that cycle.
// Sequencing:
//   Remove from empty, insert into full or into empty: the result is
//   registered at the transfer. Remove: one memory read of the head, then
//   the result. Insert into a non-empty queue: one held entry per cycle,
//   walked from the tail toward the head through the memory read port while
//   the write port moves each equal or larger entry one place back. busy
//   stays high until the result is registered.
// Reset:
//   rst_n clears the fill count, pointers and sequencer; memory contents are
//   left as they are, only the held entries from head to tail are ever used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = SPQ_QUEUE_DEPTH,
  parameter int TOKEN_BITS  = SPQ_TOKEN_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_req_type,
  input  logic [FIELD_W-1:0]  in_token_in,
  input  logic [FIELD_W-1:0]  in_cust_id_in,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [FIELD_W-1:0]  out_token_out,
  output logic [FIELD_W-1:0]  out_cust_id_out,
  output logic [FILL_W-1:0]   out_fill_level
);

`include "sorted_priority_queue_macros.svh"

  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = TOKEN_BITS + FIELD_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  state_t state_r, state_nxt;

  logic [ENTRY_W-1:0] mem_r [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [TOKEN_BITS-1:0] tok_r, tok_nxt;
  logic [FIELD_W-1:0]    cid_r, cid_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [FIELD_W-1:0]    out_token_r, out_token_nxt;
  logic [FIELD_W-1:0]    out_cid_r, out_cid_nxt;
  logic [FILL_W-1:0]     out_fill_r, out_fill_nxt;

  logic                  accept;
  logic [TOKEN_BITS-1:0] in_tok;
  logic [TOKEN_BITS-1:0] rd_tok;
  logic [FIELD_W-1:0]    rd_cid;
  logic                  shift_up;
  logic [ADDR_W-1:0]     tail_dec;
  logic [ADDR_W-1:0]     tail_inc;
  logic [ADDR_W-1:0]     head_inc;
  logic [ADDR_W-1:0]     rd_dec;
  logic [CNT_W-1:0]      count_inc;
  logic [CNT_W-1:0]      count_dec;

  assign accept   = start && !busy;
  assign in_tok   = TOKEN_BITS'(in_token_in);
  assign rd_tok   = rd_data_r[ENTRY_W-1:FIELD_W];
  assign rd_cid   = rd_data_r[FIELD_W-1:0];
  assign shift_up = (rd_tok >= tok_r);

  assign tail_dec  = (tail_r == '0) ? LAST_ADDR : tail_r - 1'b1;
  assign tail_inc  = (tail_r == LAST_ADDR) ? '0 : tail_r + 1'b1;
  assign head_inc  = (head_r == LAST_ADDR) ? '0 : head_r + 1'b1;
  assign rd_dec    = (rd_addr_r == '0) ? LAST_ADDR : rd_addr_r - 1'b1;
  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_REMOVE) begin
            if (count_r != '0) begin
              state_nxt = ST_RM_READ;
            end
          end else if (count_r != FULL_CNT && count_r != '0) begin
            state_nxt = ST_INS_SCAN;
          end
        end
      end
      ST_RM_READ: begin
        state_nxt = ST_IDLE;
      end
      ST_INS_SCAN: begin
        if (!shift_up) begin
          state_nxt = ST_IDLE;
        end else if (rd_addr_r == head_r) begin
          state_nxt = ST_INS_LAST;
        end
      end
      ST_INS_LAST: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, memory control and result
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    rd_addr_nxt    = rd_addr_r;
    wr_addr_nxt    = wr_addr_r;
    count_nxt      = count_r;
    tok_nxt        = tok_r;
    cid_nxt        = cid_r;
    mem_we         = 1'b0;
    mem_wa         = wr_addr_r;
    mem_wd         = {tok_r, cid_r};
    out_valid_nxt  = 1'b0;
    out_status_nxt = STATUS_DONE;
    out_token_nxt  = '0;
    out_cid_nxt    = '0;
    out_fill_nxt   = FILL_W'(count_r);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          tok_nxt = in_tok;
          cid_nxt = in_cust_id_in;
          if (in_req_type == REQ_REMOVE) begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_EMPTY;
            end else begin
              rd_addr_nxt = head_r;
            end
          end else if (count_r == FULL_CNT) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_FULL;
          end else if (count_r == '0) begin
            mem_we        = 1'b1;
            mem_wa        = tail_r;
            mem_wd        = {in_tok, in_cust_id_in};
            tail_nxt      = tail_inc;
            count_nxt     = count_inc;
            out_valid_nxt = 1'b1;
            out_fill_nxt  = FILL_W'(count_inc);
          end else begin
            rd_addr_nxt = tail_dec;
            wr_addr_nxt = tail_r;
          end
        end
      end
      ST_RM_READ: begin
        head_nxt      = head_inc;
        count_nxt     = count_dec;
        out_valid_nxt = 1'b1;
        out_token_nxt = FIELD_W'(rd_tok);
        out_cid_nxt   = rd_cid;
        out_fill_nxt  = FILL_W'(count_dec);
      end
      ST_INS_SCAN: begin
        mem_we = 1'b1;
        if (shift_up) begin
          // move the equal or larger entry one place toward the tail
          mem_wd      = rd_data_r;
          wr_addr_nxt = rd_addr_r;
          if (rd_addr_r != head_r) begin
            rd_addr_nxt = rd_dec;
          end
        end else begin
          tail_nxt      = tail_inc;
          count_nxt     = count_inc;
          out_valid_nxt = 1'b1;
          out_fill_nxt  = FILL_W'(count_inc);
        end
      end
      ST_INS_LAST: begin
        mem_we        = 1'b1;
        tail_nxt      = tail_inc;
        count_nxt     = count_inc;
        out_valid_nxt = 1'b1;
        out_fill_nxt  = FILL_W'(count_inc);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    wr_addr_r    <= wr_addr_nxt;
    tok_r        <= tok_nxt;
    cid_r        <= cid_nxt;
    out_status_r <= out_status_nxt;
    out_token_r  <= out_token_nxt;
    out_cid_r    <= out_cid_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem_r[rd_addr_nxt];
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_token_out   = out_token_r;
  assign out_cust_id_out = out_cid_r;
  assign out_fill_level  = out_fill_r;

  `SPQ_CHECK(a_count_bound, count_r <= FULL_CNT, "fill count above capacity")
  `SPQ_CHECK(a_count_moves_with_result, (count_r != $past(count_r)) |-> out_valid_r,
    "fill count changed without a result")
  `SPQ_CHECK(a_scan_no_collision, (state_r == ST_INS_SCAN && mem_we) |-> (mem_wa != rd_addr_nxt),
    "scan write collides with read")
  `SPQ_CHECK_NEXT(a_empty_remove, accept && in_req_type == REQ_REMOVE && count_r == '0,
    out_valid_r && out_status_r == STATUS_EMPTY, "remove from empty not flagged")
  `SPQ_CHECK_NEXT(a_full_insert, accept && in_req_type == REQ_INSERT && count_r == FULL_CNT,
    out_valid_r && out_status_r == STATUS_FULL && count_r == FULL_CNT,
    "insert into full not refused")

endmodule

>>> sim/sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Sends insert and remove requests in bursts with random gaps and keeps a
// sorted copy of the held entries to predict each result. Every result is
// compared field by field, in order, against the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_tb
  import spq_pkg::*;
();

  localparam int RANDOM_REQUESTS = 1600;
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int DRAIN_CYCLES    = 24;
  localparam logic [FIELD_W-1:0] TOKEN_MASK = FIELD_W'((1 << SPQ_TOKEN_BITS) - 1);

  typedef struct {
    logic               req_type;
    logic [FIELD_W-1:0] token;
    logic [FIELD_W-1:0] cust_id;
  } spq_request_t;

  typedef struct {
    logic [FIELD_W-1:0] token;
    logic [FIELD_W-1:0] cust_id;
  } held_entry_t;

  typedef struct {
    status_t            status;
    logic [FIELD_W-1:0] token;
    logic [FIELD_W-1:0] cust_id;
    logic [FILL_W-1:0]  fill_level;
  } spq_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_req_type = REQ_INSERT;
  logic [FIELD_W-1:0]  in_token_in = '0;
  logic [FIELD_W-1:0]  in_cust_id_in = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [FIELD_W-1:0]  out_token_out;
  logic [FIELD_W-1:0]  out_cust_id_out;
  logic [FILL_W-1:0]   out_fill_level;

  spq_request_t pending_requests[$];
  spq_result_t  expected_results[$];
  held_entry_t  held_entries[$];
  spq_request_t presented_request;
  int           error_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           gap_left = 0;

  sorted_priority_queue DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_token_in     (in_token_in),
    .in_cust_id_in   (in_cust_id_in),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_token_out   (out_token_out),
    .out_cust_id_out (out_cust_id_out),
    .out_fill_level  (out_fill_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the sorted copy and return the result it gives.
  function automatic spq_result_t serve_request(spq_request_t r);
    spq_result_t res;
    held_entry_t ent;
    int          pos;
    res.status  = STATUS_DONE;
    res.token   = '0;
    res.cust_id = '0;
    if (r.req_type == REQ_INSERT) begin
      if (held_entries.size() >= SPQ_QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        ent.token   = r.token & TOKEN_MASK;
        ent.cust_id = r.cust_id;
        pos = 0;
        while (pos < held_entries.size() && ent.token > held_entries[pos].token) pos++;
        held_entries.insert(pos, ent);
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        ent = held_entries.pop_front();
        res.token   = ent.token;
        res.cust_id = ent.cust_id;
      end
    end
    res.fill_level = FILL_W'(held_entries.size());
    return res;
  endfunction

  task automatic add_request(logic req_type, logic [FIELD_W-1:0] token,
                             logic [FIELD_W-1:0] cust_id);
    spq_request_t r;
    r.req_type = req_type;
    r.token    = token;
    r.cust_id  = cust_id;
    pending_requests.push_back(r);
  endtask

  task automatic check_field(string name, logic [FIELD_W-1:0] expv,
                             logic [FIELD_W-1:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
      error_count++;
    end
  endtask

  // Driver: present requests in bursts, hold while busy.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) expected_results.push_back(serve_request(presented_request));
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        presented_request = pending_requests.pop_front();
        in_req_type   <= presented_request.req_type;
        in_token_in   <= presented_request.token;
        in_cust_id_in <= presented_request.cust_id;
        start         <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1, 2:    gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 30);
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is compared against the oldest prediction.
  always @(posedge clk) begin
    spq_result_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d token %h id %h",
                 $time, out_status, out_token_out, out_cust_id_out);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("status", FIELD_W'(exp_res.status), FIELD_W'(out_status));
        check_field("token", exp_res.token, out_token_out);
        check_field("cust_id", exp_res.cust_id, out_cust_id_out);
        check_field("fill_level", FIELD_W'(exp_res.fill_level), FIELD_W'(out_fill_level));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int                 made;
    int                 phase_len;
    int                 insert_pct;
    logic               req_type;
    logic [FIELD_W-1:0] token;

    // Directed: remove from empty, extreme and equal tokens, fill, overflow.
    add_request(REQ_REMOVE, 16'h1234, 16'hABCD);
    add_request(REQ_INSERT, 16'hFFFF, 16'hFFFF);
    add_request(REQ_INSERT, 16'h0000, 16'h0000);
    add_request(REQ_INSERT, 16'h8000, 16'h1111);
    add_request(REQ_INSERT, 16'h8000, 16'h2222);
    add_request(REQ_INSERT, 16'h8000, 16'h3333);
    add_request(REQ_INSERT, 16'h0000, 16'h4444);
    add_request(REQ_INSERT, 16'hFFFF, 16'h5555);
    for (int i = 0; i < 9; i++)
      add_request(REQ_INSERT, FIELD_W'($urandom), FIELD_W'($urandom));
    add_request(REQ_INSERT, 16'h0001, 16'h7777);
    for (int i = 0; i < 5; i++)
      add_request(REQ_REMOVE, FIELD_W'($urandom), FIELD_W'($urandom));

    // Random phases, each leaning toward inserts or removes.
    made = 0;
    while (made < RANDOM_REQUESTS) begin
      phase_len = $urandom_range(16, 96);
      case ($urandom_range(0, 4))
        0:       insert_pct = 90;
        1:       insert_pct = 70;
        2:       insert_pct = 50;
        3:       insert_pct = 30;
        default: insert_pct = 10;
      endcase
      for (int i = 0; i < phase_len && made < RANDOM_REQUESTS; i++) begin
        req_type = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        case ($urandom_range(0, 3))
          0:       token = FIELD_W'($urandom_range(0, 7));
          1:       token = 16'hFFF8 | FIELD_W'($urandom_range(0, 7));
          default: token = FIELD_W'($urandom);
        endcase
        add_request(req_type, token, FIELD_W'($urandom));
        made++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    wait (rst_n);
    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sorted_priority_queue.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/sorted_priority_queue.sv
sim/sorted_priority_queue_tb.sv
